### design/bpe_pkg.sv
package bpe_pkg;

    localparam int MAX_X_TERMS = 4;
    localparam int MAX_Y_TERMS = 4;
    localparam int STORE_DEPTH = MAX_X_TERMS * MAX_Y_TERMS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int XN_W        = $clog2(MAX_X_TERMS + 1);
    localparam int YN_W        = $clog2(MAX_Y_TERMS + 1);
    localparam int XI_W        = (MAX_X_TERMS > 1) ? $clog2(MAX_X_TERMS) : 1;
    localparam int YJ_W        = (MAX_Y_TERMS > 1) ? $clog2(MAX_Y_TERMS) : 1;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 48;

    localparam logic signed [47:0] MAX48 = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] MIN48 = {1'b1, {47{1'b0}}};
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        REG_X_TERMS       = 2'd0,
        REG_Y_TERMS       = 2'd1,
        REG_PERT_AMOUNT   = 2'd2,
        REG_PERT_RELATIVE = 2'd3
    } t_reg_idx;

    // Request to the shared multiplier: a * b, rounded and scaled down by
    // 2^16 (frac16) or 2^30, saturated to 48 bits.
    typedef struct packed {
        logic        start;
        logic        frac16;
        logic [47:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [47:0] value;
    } t_mul_rsp;

    typedef struct packed {
        logic        ovf;
        logic [47:0] value;
    } t_sat48;

    function automatic t_sat48 sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        t_sat48      r;
        s       = {a[47], a} + {b[47], b};
        r.ovf   = s[48] ^ s[47];
        r.value = r.ovf ? (s[48] ? MIN48 : MAX48) : s[47:0];
        return r;
    endfunction

endpackage

### design/bivariate_poly_eval.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   i_s_axis_tvalid/o_..._tready  tdata: index, coeff, x, y, perturb index
//                                              tuser: request type
// m_axis    out  o_m_axis_tvalid/i_..._tready  tdata: result; tuser: overflow
// cfg       in   i_cfg_wr_en (no wait)         i_cfg_addr, i_cfg_wdata
//
// A load transfer writes the coefficient into the store on the accept edge.
// An evaluate transfer is paced by the one shared 48x32 multiplier (two passes of a
// 33x32 product, one call per x step, per row weight, per y power and for a relative
// perturbation) and the saturating adder it shares with the sums.
// Input is refused from the accept of an evaluation until its result sits in the
// output register; that register frees the sequencer while the result waits.
// Reset (synchronous, active low) clears the control state and the registers
// to x_terms 1, y_terms 1, pert_amount 0, absolute mode; the store is not cleared.
module bivariate_poly_eval (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [3:0] coeff_index, [35:4] coeff_value, [67:36] x_value,
    // [99:68] y_value, [104:100] perturb_index, [111:105] zero
    input  logic [bpe_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [0] req_type
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [47:0] result_value
    output logic [bpe_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // [0] overflow
    output logic                             o_m_axis_tuser,
    input  logic                             i_cfg_wr_en,
    input  logic [1:0]                       i_cfg_addr,
    input  logic [31:0]                      i_cfg_wdata
);
    import bpe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW,
        S_RD,
        S_COEF,
        S_PWAIT,
        S_PADD,
        S_ACC,
        S_XMUL,
        S_XWAIT,
        S_YMUL,
        S_YWAIT,
        S_VADD,
        S_YPMUL,
        S_YPWAIT,
        S_DONE
    } t_state;

    // Configuration registers
    logic [2:0]  r_x_terms;
    logic [2:0]  r_y_terms;
    logic [31:0] r_pert_amount;
    logic        r_pert_rel;

    // Sequencer state
    t_state            r_state;
    logic [XN_W-1:0]   r_nx;
    logic [YN_W-1:0]   r_ny;
    logic [XI_W-1:0]   r_i;
    logic [YJ_W-1:0]   r_j;
    logic [ADDR_W-1:0] r_row_base;
    logic [31:0]       r_x;
    logic [31:0]       r_y;
    logic [4:0]        r_pidx;
    logic [47:0]       r_val;
    logic [47:0]       r_sub;
    logic [47:0]       r_coef;
    logic [47:0]       r_opnd;
    logic [31:0]       r_ypow;
    logic              r_ov;

    // Output register
    logic              r_m_valid;
    logic [47:0]       r_m_data;
    logic              r_m_user;

    logic              in_xfer;
    logic              load_we;
    logic [ADDR_W-1:0] load_addr;
    logic [ADDR_W-1:0] pos;
    logic [31:0]       rd_data;
    logic              pert_hit;
    logic              more_rows;
    logic              out_free;
    logic [XN_W-1:0]   nx_eff;
    logic [YN_W-1:0]   ny_eff;
    logic [47:0]       add_a;
    logic [47:0]       add_b;
    t_sat48            add_res;
    t_mul_req          mul_req;
    t_mul_rsp          mul_rsp;
    logic              yp_fits;
    logic [31:0]       yp_clamped;

    // Input fields
    logic [3:0]  in_coeff_index;
    logic [31:0] in_coeff_value;
    logic [31:0] in_x_value;
    logic [31:0] in_y_value;
    logic [4:0]  in_perturb_index;

    assign in_coeff_index   = i_s_axis_tdata[3:0];
    assign in_coeff_value   = i_s_axis_tdata[35:4];
    assign in_x_value       = i_s_axis_tdata[67:36];
    assign in_y_value       = i_s_axis_tdata[99:68];
    assign in_perturb_index = i_s_axis_tdata[104:100];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // Loads bypass the sequencer; drop an index beyond the store.
    assign load_we   = in_xfer && (t_req_type'(i_s_axis_tuser) == REQ_LOAD)
                       && (int'(in_coeff_index) < STORE_DEPTH);
    assign load_addr = ADDR_W'(in_coeff_index);

    assign pos       = r_row_base + ADDR_W'(r_i);
    assign pert_hit  = (int'(pos) == int'(r_pidx));
    assign more_rows = (int'(r_j) + 1) < int'(r_ny);
    assign out_free  = !r_m_valid || i_m_axis_tready;

    // A term count of zero means one; clip above the maximum.
    always_comb begin
        if (r_x_terms == '0) begin
            nx_eff = XN_W'(1);
        end else if (int'(r_x_terms) > MAX_X_TERMS) begin
            nx_eff = XN_W'(MAX_X_TERMS);
        end else begin
            nx_eff = XN_W'(r_x_terms);
        end
        if (r_y_terms == '0) begin
            ny_eff = YN_W'(1);
        end else if (int'(r_y_terms) > MAX_Y_TERMS) begin
            ny_eff = YN_W'(MAX_Y_TERMS);
        end else begin
            ny_eff = YN_W'(r_y_terms);
        end
    end

    bpe_store u_store (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_addr),
        .i_wdata (in_coeff_value),
        .i_raddr (pos),
        .o_rdata (rd_data)
    );

    // Shared saturating adder: perturbation, row sum, total.
    always_comb begin
        case (r_state)
            S_PADD: begin
                add_a = r_coef;
                add_b = r_opnd;
            end
            S_ACC: begin
                add_a = r_sub;
                add_b = r_coef;
            end
            default: begin
                add_a = r_val;
                add_b = r_opnd;
            end
        endcase
    end

    assign add_res = sat_add48(add_a, add_b);

    // Shared multiplier requests.
    always_comb begin
        mul_req = '0;
        case (r_state)
            S_COEF: begin
                mul_req.start  = pert_hit && r_pert_rel && (rd_data != '0);
                mul_req.frac16 = 1'b1;
                mul_req.a      = {{16{rd_data[31]}}, rd_data};
                mul_req.b      = r_pert_amount;
            end
            S_XMUL: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_sub;
                mul_req.b     = r_x;
            end
            S_YMUL: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_sub;
                mul_req.b     = r_ypow;
            end
            S_YPMUL: begin
                mul_req.start = 1'b1;
                mul_req.a     = {{16{r_ypow[31]}}, r_ypow};
                mul_req.b     = r_y;
            end
            default: mul_req = '0;
        endcase
    end

    bpe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // The y power stays in Q2.30 within 32 bits.
    assign yp_fits    = (&mul_rsp.value[47:31]) | ~(|mul_rsp.value[47:31]);
    assign yp_clamped = yp_fits ? mul_rsp.value[31:0]
                                : (mul_rsp.value[47] ? MIN32 : MAX32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_terms     <= 3'd1;
            r_y_terms     <= 3'd1;
            r_pert_amount <= '0;
            r_pert_rel    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_X_TERMS:       r_x_terms     <= i_cfg_wdata[2:0];
                REG_Y_TERMS:       r_y_terms     <= i_cfg_wdata[2:0];
                REG_PERT_AMOUNT:   r_pert_amount <= i_cfg_wdata;
                REG_PERT_RELATIVE: r_pert_rel    <= i_cfg_wdata[0];
                default:           r_pert_rel    <= r_pert_rel;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            // Load the output register from the sequencer, else drop the
            // result once it has been taken.
            if ((r_state == S_DONE) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && (t_req_type'(i_s_axis_tuser) == REQ_EVAL)) begin
                        r_x        <= in_x_value;
                        r_y        <= in_y_value;
                        r_pidx     <= in_perturb_index;
                        r_nx       <= nx_eff;
                        r_ny       <= ny_eff;
                        r_j        <= '0;
                        r_row_base <= '0;
                        r_val      <= '0;
                        r_ypow     <= ONE_Q30;
                        r_ov       <= 1'b0;
                        r_state    <= S_ROW;
                    end
                end
                S_ROW: begin
                    // Horner runs from the highest x term down.
                    r_sub   <= '0;
                    r_i     <= XI_W'(r_nx - XN_W'(1));
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_COEF;
                end
                S_COEF: begin
                    r_coef <= {{16{rd_data[31]}}, rd_data};
                    if (!pert_hit) begin
                        r_state <= S_ACC;
                    end else if (r_pert_rel && (rd_data != '0)) begin
                        r_state <= S_PWAIT;
                    end else begin
                        r_opnd  <= {{16{r_pert_amount[31]}}, r_pert_amount};
                        r_state <= S_PADD;
                    end
                end
                S_PWAIT: begin
                    if (mul_rsp.done) begin
                        r_opnd  <= mul_rsp.value;
                        r_state <= S_PADD;
                    end
                end
                S_PADD: begin
                    r_coef  <= add_res.value;
                    r_ov    <= r_ov | add_res.ovf;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sub   <= add_res.value;
                    r_ov    <= r_ov | add_res.ovf;
                    r_state <= (r_i != '0) ? S_XMUL : S_YMUL;
                end
                S_XMUL: begin
                    r_state <= S_XWAIT;
                end
                S_XWAIT: begin
                    if (mul_rsp.done) begin
                        r_sub   <= mul_rsp.value;
                        r_ov    <= r_ov | mul_rsp.ovf;
                        r_i     <= r_i - XI_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_YMUL: begin
                    r_state <= S_YWAIT;
                end
                S_YWAIT: begin
                    if (mul_rsp.done) begin
                        r_opnd  <= mul_rsp.value;
                        r_ov    <= r_ov | mul_rsp.ovf;
                        r_state <= S_VADD;
                    end
                end
                S_VADD: begin
                    r_val   <= add_res.value;
                    r_ov    <= r_ov | add_res.ovf;
                    r_state <= more_rows ? S_YPMUL : S_DONE;
                end
                S_YPMUL: begin
                    r_state <= S_YPWAIT;
                end
                S_YPWAIT: begin
                    if (mul_rsp.done) begin
                        r_ypow     <= yp_clamped;
                        r_ov       <= r_ov | mul_rsp.ovf | ~yp_fits;
                        r_j        <= r_j + YJ_W'(1);
                        r_row_base <= r_row_base + ADDR_W'(r_nx);
                        r_state    <= S_ROW;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free.
                    if (out_free) begin
                        r_m_data  <= r_val;
                        r_m_user  <= r_ov;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule

### design/bpe_store.sv
module bpe_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [bpe_pkg::ADDR_W-1:0] i_waddr,
    input  logic [31:0]                i_wdata,
    input  logic [bpe_pkg::ADDR_W-1:0] i_raddr,
    output logic [31:0]                o_rdata
);
    import bpe_pkg::*;

    logic [31:0] mem [STORE_DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/bpe_mul.sv
module bpe_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpe_pkg::t_mul_req i_req,
    output bpe_pkg::t_mul_rsp o_rsp
);
    import bpe_pkg::*;

    typedef enum logic {
        M_IDLE,
        M_HI
    } t_mstate;

    t_mstate            r_state;
    logic               r_done;
    logic               r_frac16;
    logic [15:0]        r_ahi;
    logic signed [31:0] r_b;
    logic signed [79:0] r_acc;

    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] prod;
    logic signed [79:0] rnd;
    logic signed [79:0] shifted;
    logic               fits;

    // Low word (unsigned) on the start cycle, signed high part on the next.
    always_comb begin
        if (r_state == M_IDLE) begin
            mul_a = $signed({1'b0, i_req.a[31:0]});
            mul_b = $signed(i_req.b);
        end else begin
            mul_a = $signed({{17{r_ahi[15]}}, r_ahi});
            mul_b = r_b;
        end
    end

    assign prod = mul_a * mul_b;
    assign rnd  = i_req.frac16 ? 80'sd32768 : 80'sd536870912;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_acc    <= $signed({{15{prod[64]}}, prod}) + rnd;
                        r_ahi    <= i_req.a[47:32];
                        r_b      <= $signed(i_req.b);
                        r_frac16 <= i_req.frac16;
                        r_state  <= M_HI;
                    end
                end
                M_HI: begin
                    r_acc   <= r_acc + $signed({prod[47:0], 32'h0});
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    // Floor shift, then saturate to 48 bits.
    assign shifted = r_frac16 ? (r_acc >>> 16) : (r_acc >>> 30);
    assign fits    = (&shifted[79:47]) | ~(|shifted[79:47]);

    always_comb begin
        o_rsp.done  = r_done;
        o_rsp.ovf   = ~fits;
        o_rsp.value = fits ? shifted[47:0] : (shifted[79] ? MIN48 : MAX48);
    end

endmodule

### sim/poly_eval_check.sv
`timescale 1ns / 1ps

module poly_eval_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    // [3:0] coeff_index, [35:4] coeff_value, [67:36] x_value,
    // [99:68] y_value, [104:100] perturb_index, [111:105] zero
    input  logic [bpe_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] req_type
    input  logic                           i_s_axis_tuser,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [47:0] result_value
    input  logic [bpe_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    // [0] overflow
    input  logic                           i_m_axis_tuser,
    input  logic                           i_cfg_wr_en,
    input  logic [1:0]                     i_cfg_addr,
    input  logic [31:0]                    i_cfg_wdata,
    output int                             o_mismatches,
    output int                             o_outstanding,
    output int                             o_results
);
    import bpe_pkg::*;

    typedef struct packed {
        logic [47:0] value;
        logic        ovf;
    } t_poly_result;

    localparam logic signed [127:0] Q30_HALF = 128'sd536870912;
    localparam logic signed [127:0] Q16_HALF = 128'sd32768;

    logic signed [31:0] coeff_mem [STORE_DEPTH];
    logic [2:0]         x_terms_q;
    logic [2:0]         y_terms_q;
    logic signed [31:0] pert_amount_q;
    logic               pert_rel_q;
    logic               step_ovf;
    t_poly_result       pending_values [$];
    int                 mismatch_cnt;
    int                 result_cnt;

    function automatic logic signed [47:0] clamp48(input logic signed [127:0] v);
        if (v > MAX48) begin
            step_ovf = 1'b1;
            return MAX48;
        end
        if (v < MIN48) begin
            step_ovf = 1'b1;
            return MIN48;
        end
        return v[47:0];
    endfunction

    // a * b / 2^30, rounded half up, saturated to 48 bits
    function automatic logic signed [47:0] mul_q30(input logic signed [47:0] a,
                                                   input logic signed [31:0] b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return clamp48((wa * wb + Q30_HALF) >>> 30);
    endfunction

    function automatic int term_count(input logic [2:0] v, input int limit);
        if (v == 3'd0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    // Horner along x inside each row, running power of y across rows.
    function automatic t_poly_result poly_value(input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                input logic [4:0]         pidx);
        int                  nx;
        int                  ny;
        int                  pos;
        int                  i;
        int                  j;
        logic signed [47:0]  acc;
        logic signed [47:0]  row;
        logic signed [31:0]  ypow;
        logic signed [127:0] w;
        logic signed [127:0] adj;
        t_poly_result        r;
        step_ovf = 1'b0;
        nx   = term_count(x_terms_q, MAX_X_TERMS);
        ny   = term_count(y_terms_q, MAX_Y_TERMS);
        acc  = '0;
        ypow = ONE_Q30;
        for (j = 0; j < ny; j++) begin
            row = '0;
            for (i = nx - 1; i >= 0; i--) begin
                pos = j * nx + i;
                w   = coeff_mem[pos];
                if (pos == int'(pidx)) begin
                    adj = pert_amount_q;
                    if (pert_rel_q && w != 0)
                        adj = (w * adj + Q16_HALF) >>> 16;
                    w = clamp48(w + adj);
                end
                w   = w + row;
                row = clamp48(w);
                if (i > 0)
                    row = mul_q30(row, x);
            end
            w   = acc;
            w   = w + mul_q30(row, ypow);
            acc = clamp48(w);
            if (j + 1 < ny) begin
                w = mul_q30(ypow, y);
                if (w > MAX32) begin
                    step_ovf = 1'b1;
                    ypow     = MAX32;
                end else if (w < MIN32) begin
                    step_ovf = 1'b1;
                    ypow     = MIN32;
                end else begin
                    ypow = w[31:0];
                end
            end
        end
        r.value = acc;
        r.ovf   = step_ovf;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_poly_result want;
        t_poly_result fresh;
        if (!i_rst_n) begin
            x_terms_q     = 3'd1;
            y_terms_q     = 3'd1;
            pert_amount_q = '0;
            pert_rel_q    = 1'b0;
            pending_values.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_reg_idx'(i_cfg_addr))
                    REG_X_TERMS:       x_terms_q = i_cfg_wdata[2:0];
                    REG_Y_TERMS:       y_terms_q = i_cfg_wdata[2:0];
                    REG_PERT_AMOUNT:   pert_amount_q = i_cfg_wdata;
                    REG_PERT_RELATIVE: pert_rel_q = i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (i_m_axis_tvalid && i_m_axis_tready) begin
                result_cnt++;
                if (pending_values.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: result transfer with no evaluation pending: value %h ovf %b",
                             $time, i_m_axis_tdata, i_m_axis_tuser);
                end else begin
                    want = pending_values.pop_front();
                    if (i_m_axis_tdata !== want.value) begin
                        mismatch_cnt++;
                        $display("%0t: result_value mismatch: expected %h actual %h",
                                 $time, want.value, i_m_axis_tdata);
                    end
                    if (i_m_axis_tuser !== want.ovf) begin
                        mismatch_cnt++;
                        $display("%0t: overflow mismatch: expected %b actual %b",
                                 $time, want.ovf, i_m_axis_tuser);
                    end
                end
            end

            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (t_req_type'(i_s_axis_tuser) == REQ_LOAD) begin
                    coeff_mem[i_s_axis_tdata[3:0]] = i_s_axis_tdata[35:4];
                end else begin
                    fresh = poly_value(i_s_axis_tdata[67:36],
                                       i_s_axis_tdata[99:68],
                                       i_s_axis_tdata[104:100]);
                    pending_values.insert(pending_values.size(), fresh);
                end
            end
        end
        o_mismatches  <= mismatch_cnt;
        o_outstanding <= pending_values.size();
        o_results     <= result_cnt;
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import bpe_pkg::*;

    localparam int RESET_CYCLES     = 5;
    // Slowest evaluation is 4x4 in relative mode.
    localparam int SETTLE_CYCLES    = 130;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT      = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en;
    logic [1:0]            cfg_addr;
    logic [31:0]           cfg_wdata;

    int   mismatches;
    int   outstanding;
    int   results;
    int   loads_sent;
    int   evals_sent;
    int   quiet_cycles;
    logic idle_on;
    logic hold_request;

    bivariate_poly_eval uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    poly_eval_check check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding),
        .o_results       (results)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Field layout of the input transfer, lowest bits first.
    function automatic logic [IN_DATA_W-1:0] pack_item(input logic [3:0]  idx,
                                                       input logic [31:0] coeff,
                                                       input logic [31:0] x,
                                                       input logic [31:0] y,
                                                       input logic [4:0]  pidx);
        return {7'd0, pidx, y, x, coeff, idx};
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 4))
            0:       return MAX32;
            1:       return MIN32;
            2:       return 32'd0;
            3:       return ONE_Q30;
            default: return -ONE_Q30;
        endcase
    endfunction

    // Q16.16 coefficient: within +-4.0 half the time so sums stay in range, with
    // full-width words and extremes mixed in to reach saturation.
    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(0, 5))
            0:       return extreme_word();
            1, 2:    return $urandom();
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    // Q2.30 point: mostly within +-1.0.
    function automatic logic [31:0] rand_point();
        case ($urandom_range(0, 5))
            0:       return extreme_word();
            1:       return $urandom();
            default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    // Offer one transfer, with a random gap first while idling is on; hold
    // tvalid high across back-to-back transfers.
    task automatic send_item(input t_req_type kind, input logic [IN_DATA_W-1:0] data);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (kind == REQ_LOAD)
            loads_sent++;
        else
            evals_sent++;
    endtask

    task automatic send_random_item();
        logic [4:0] pidx;
        pidx = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(0, 31));
        if ($urandom_range(0, 9) < 4)
            send_item(REQ_LOAD, pack_item(4'($urandom_range(0, 15)), rand_coeff(),
                                          $urandom(), $urandom(),
                                          5'($urandom_range(0, 31))));
        else
            send_item(REQ_EVAL, pack_item(4'($urandom_range(0, 15)), $urandom(),
                                          rand_point(), rand_point(), pidx));
    endtask

    // Write all four registers on consecutive edges; only called while idle.
    task automatic apply_settings(input logic [2:0]  nx,
                                  input logic [2:0]  ny,
                                  input logic [31:0] amount,
                                  input logic        relative);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_X_TERMS;
        cfg_wdata <= {29'd0, nx};
        @(posedge clk);
        cfg_addr  <= REG_Y_TERMS;
        cfg_wdata <= {29'd0, ny};
        @(posedge clk);
        cfg_addr  <= REG_PERT_AMOUNT;
        cfg_wdata <= amount;
        @(posedge clk);
        cfg_addr  <= REG_PERT_RELATIVE;
        cfg_wdata <= {31'd0, relative};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Drain: every evaluation answered, then let a trailing load finish.
    task automatic wait_idle();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [2:0]  nx,
                             input logic [2:0]  ny,
                             input logic [31:0] amount,
                             input logic        relative,
                             input int          count,
                             input logic        long_hold);
        apply_settings(nx, ny, amount, relative);
        if (long_hold)
            hold_request = 1'b1;
        repeat (count) send_random_item();
        s_tvalid <= 1'b0;
        wait_idle();
    endtask

    // Result side: random stall bursts, plus one long hold-off on request so
    // the output register fills and the block refuses input.
    always begin
        @(posedge clk);
        if (hold_request) begin
            m_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clk);
            hold_request = 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        m_tready <= 1'b1;
    end

    // Watchdog: any transfer on either side resets the count.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("bivariate_poly_eval test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] cval;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        rst_n        = 1'b0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        loads_sent   = 0;
        evals_sent   = 0;
        quiet_cycles = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: fill the whole store first (nothing may read an
        // unwritten entry), with coefficient extremes in the low slots.
        apply_settings(3'd4, 3'd4, MAX32, 1'b1);
        for (int k = 0; k < STORE_DEPTH; k++) begin
            case (k)
                0:       cval = MAX32;
                1:       cval = MIN32;
                2:       cval = 32'd0;
                3:       cval = 32'hFFFF_FFFF;
                4:       cval = 32'h0001_0000;
                default: cval = rand_coeff();
            endcase
            send_item(REQ_LOAD, pack_item(4'(k), cval, $urandom(), $urandom(), 5'd16));
        end
        // Relative perturbation of a full-scale coefficient at the largest point.
        send_item(REQ_EVAL, pack_item(4'd0, 32'd0, MAX32, MAX32, 5'd0));
        // Relative mode on a zero coefficient falls back to the plain amount.
        send_item(REQ_EVAL, pack_item(4'hF, MAX32, MIN32, MIN32, 5'd2));
        // No perturbation, origin.
        send_item(REQ_EVAL, pack_item(4'd0, 32'd0, 32'd0, 32'd0, 5'd16));
        // Perturb index beyond the store.
        send_item(REQ_EVAL, pack_item(4'd0, 32'd0, ONE_Q30, ONE_Q30, 5'd31));
        // Most negative coefficient perturbed.
        send_item(REQ_EVAL, pack_item(4'd0, 32'd0, -ONE_Q30, 32'h2000_0000, 5'd1));
        s_tvalid <= 1'b0;
        wait_idle();

        // Random phases: term counts include 0 and 7 (clamped by the block),
        // perturbation amount at both extremes and both modes.
        run_phase(3'd1, 3'd1, 32'd0, 1'b0, 280, 1'b0);
        run_phase(3'd4, 3'd4, MAX32, 1'b0, 200, 1'b1);
        run_phase(3'd0, 3'd7, MIN32, 1'b1, 200, 1'b0);
        run_phase(3'd7, 3'd0, $urandom(), 1'b1, 200, 1'b0);
        run_phase(3'd2, 3'd3, $urandom_range(0, 32'h0002_0000) - 32'h0001_0000, 1'b0,
                  200, 1'b0);
        run_phase(3'd3, 3'd4, $urandom_range(0, 32'h0002_0000) - 32'h0001_0000, 1'b1,
                  200, 1'b0);
        run_phase(3'd4, 3'd2, $urandom(), 1'b0, 200, 1'b0);
        // Last stretch at full rate on both sides.
        idle_on = 1'b0;
        run_phase(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  $urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
                  1'($urandom_range(0, 1)), 200, 1'b0);

        $display("Covered %0d coefficient loads and %0d evaluations across nine register",
                 loads_sent, evals_sent);
        $display("settings (term counts 0 to 7, both perturbation modes); %0d results compared.",
                 results);
        if (mismatches == 0 && outstanding == 0)
            $display("bivariate_poly_eval test passed");
        else
            $display("bivariate_poly_eval test failed");
        $finish;
    end

endmodule
